@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the clock, off while reset is held
`define AST_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also runs during reset
`define AST_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/ib64e_pkg.sv @@
// shared types, constants and the base64 alphabet function
package ib64e_pkg;

  localparam int unsigned GroupBits        = 6;
  localparam int unsigned AccW             = 5;
  localparam int unsigned CntW             = 3;
  localparam int unsigned CfgW             = 6;
  localparam int unsigned ValueW           = 32;
  localparam int unsigned SymW             = 7;
  localparam int unsigned MaxValueWidthDef = 32;
  localparam logic [CfgW-1:0] CfgReset     = 6'd8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic store;
  } ib64e_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_char;
    logic out_free;
  } ib64e_sts_t;

  // 6-bit group to ascii code of the base64 alphabet
  function automatic logic [SymW-1:0] to_symbol(input logic [GroupBits-1:0] code);
    logic [SymW-1:0] sym;
    if (code < 6'd26) begin
      sym = 7'd65 + {1'b0, code};
    end else if (code < 6'd52) begin
      sym = 7'd97 + {1'b0, code - 6'd26};
    end else if (code < 6'd62) begin
      sym = 7'd48 + {1'b0, code - 6'd52};
    end else if (code == 6'd62) begin
      sym = 7'd43;
    end else begin
      sym = 7'd47;
    end
    return sym;
  endfunction

endpackage

@@ hdl/int_stream_base64_encoder.sv @@
// top level of the integer stream base64 encoder
//
// Input beats on s_axis carry one integer in tdata; its low value_width bits
// are appended msb first to a running bit stream. tlast marks the last
// integer of a stream, which pads any kept bits with zeros to one more
// character. Output beats on m_axis carry one base64 ascii character each;
// m_axis_tlast marks the final character of a stream. A last item that
// produces no character gives no beat at all.
// The cfg channel writes value_width (reset 8) and is always ready; write it
// only while the block is idle.
// Steps: an item giving n characters (n is at most 7 here) is loaded into
// the work word, each character is then emitted in turn through the shared
// 6-bit group shifter, and the leftover bits are stored; the first character
// passes through the work word and then the output register to m_axis.
// Reset clears the leftover bits, the output valid flag and the controller.
// When the receiver stalls the output register holds its beat and the
// shifter waits; a new item is taken once the previous one is fully emitted.
module int_stream_base64_encoder #(
  parameter int unsigned MAX_VALUE_WIDTH = ib64e_pkg::MaxValueWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // value[31:0]
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // symbol[6:0], zero[7]
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ib64e_pkg::CfgW-1:0]   cfg_data_i
);

  ib64e_pkg::ib64e_cmd_t      cmd;
  ib64e_pkg::ib64e_sts_t      sts;
  logic [ib64e_pkg::SymW-1:0] symbol;

  assign cfg_ready_o = 1'b1;

  // controller
  ib64e_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  ib64e_datapath #(
    .MAX_VALUE_WIDTH (MAX_VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_symbol_o (symbol),
    .out_final_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, symbol};

endmodule

@@ hdl/ib64e_datapath.sv @@
// bit packing datapath: carry bits, aligned work word, output register
module ib64e_datapath #(
  parameter int unsigned MAX_VALUE_WIDTH = ib64e_pkg::MaxValueWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ib64e_pkg::ib64e_cmd_t        cmd_i,
  output ib64e_pkg::ib64e_sts_t        sts_o,
  input  logic [ib64e_pkg::ValueW-1:0] value_i,
  input  logic                         last_i,
  input  logic                         cfg_valid_i,
  input  logic [ib64e_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [ib64e_pkg::SymW-1:0]   out_symbol_o,
  output logic                         out_final_o
);

  localparam int unsigned MaxW = MAX_VALUE_WIDTH;
  localparam int unsigned TW   = MaxW + ib64e_pkg::AccW;
  localparam int unsigned RW   = $clog2(TW + 1);
  localparam int unsigned WW   = $clog2(MaxW + 1);
  localparam int unsigned G    = ib64e_pkg::GroupBits;

  logic [ib64e_pkg::CfgW-1:0] cfg_q;
  logic [ib64e_pkg::AccW-1:0] acc_q, acc_d;
  logic [ib64e_pkg::CntW-1:0] bc_q, bc_d;
  logic [TW-1:0]              work_q, work_d;
  logic [RW-1:0]              rem_q, rem_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [ib64e_pkg::SymW-1:0] out_sym_q, out_sym_d;
  logic                       out_fin_q, out_fin_d;

  logic [WW-1:0]   w_eff;
  logic [MaxW-1:0] val_ext, val_mask;
  logic [TW-1:0]   joined;
  logic [RW-1:0]   tot_bits;
  logic [RW-1:0]   sh_amt;
  logic [G-1:0]    top_grp;
  logic            rem_ge_g;

  // effective width, clipped to the parameter
  always_comb begin
    if (int'(cfg_q) > int'(MaxW)) begin
      w_eff = WW'(MaxW);
    end else begin
      w_eff = WW'(cfg_q);
    end
  end

  // value bits beyond the port read as zero
  assign val_ext = MaxW'({{MaxW{1'b0}}, value_i});

  // carried bits directly above the selected value bits, then left aligned
  always_comb begin
    val_mask = val_ext & ~({MaxW{1'b1}} << w_eff);
    joined   = (TW'(acc_q) << w_eff) | TW'(val_mask);
    tot_bits = RW'(bc_q) + RW'(w_eff);
    sh_amt   = RW'(TW) - tot_bits;
  end

  assign top_grp  = work_q[TW-1 -: G];
  assign rem_ge_g = (rem_q >= RW'(G));

  assign sts_o.has_char = rem_ge_g || (last_q && (rem_q != '0));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // next state of the work word and the carry
  always_comb begin
    work_d      = work_q;
    rem_d       = rem_q;
    last_d      = last_q;
    acc_d       = acc_q;
    bc_d        = bc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sym_d   = out_sym_q;
    out_fin_d   = out_fin_q;
    if (cmd_i.load) begin
      work_d = joined << sh_amt;
      rem_d  = tot_bits;
      last_d = last_i;
    end else if (cmd_i.emit) begin
      work_d      = work_q << G;
      rem_d       = rem_ge_g ? (rem_q - RW'(G)) : '0;
      out_valid_d = 1'b1;
      out_sym_d   = ib64e_pkg::to_symbol(top_grp);
      out_fin_d   = last_q && (rem_q <= RW'(G));
    end else if (cmd_i.store) begin
      if (last_q) begin
        acc_d = '0;
        bc_d  = '0;
      end else begin
        acc_d = ib64e_pkg::AccW'(top_grp >> (3'd6 - rem_q[ib64e_pkg::CntW-1:0]));
        bc_d  = rem_q[ib64e_pkg::CntW-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= ib64e_pkg::CfgReset;
      acc_q       <= '0;
      bc_q        <= '0;
      rem_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      acc_q       <= acc_d;
      bc_q        <= bc_d;
      rem_q       <= rem_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    out_sym_q <= out_sym_d;
    out_fin_q <= out_fin_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_final_o  = out_fin_q;

endmodule

@@ hdl/ib64e_ctrl.sv @@
// controller: load an item, emit its characters, store leftover bits
module ib64e_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ib64e_pkg::ib64e_sts_t sts_i,
  output ib64e_pkg::ib64e_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (sts_i.has_char) begin
          cmd_o.emit = sts_i.out_free;
        end else begin
          cmd_o.store = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/ib64e_checker.sv @@
// port level checks for the encoder, bound to the top level
`include "assert_macros.svh"

module ib64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       cfg_ready_o
);

  // a stalled output beat holds
  `AST_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")

  // every character comes from the base64 alphabet range
  `AST_CLK(a_sym_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0) && (m_axis_tdata[6:0] >= 7'd43) && (m_axis_tdata[6:0] <= 7'd122), "symbol outside alphabet")

  // one item at a time: input closes after each accepted beat
  `AST_CLK(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input ready right after a beat")

  // config port always open
  `AST_CLK(a_cfg_ready, clk_i, rst_ni, cfg_ready_o, "config port not ready")

endmodule

bind int_stream_base64_encoder ib64e_checker u_ib64e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);
